[design/fmcs_pkg.sv]
// Shared types and constants for the field match comb selector.
package fmcs_pkg;

	localparam int COL_W       = 12;
	localparam int ROW_W       = 12;
	localparam int PIX_W       = 8;
	localparam int ROWS_W      = 13;
	localparam int THR_W       = 16;
	localparam int OUT_CNT_W   = 18;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam int MAGIC_CURR_LIMIT  = 50;
	localparam int MAGIC_DIFF_LIMIT  = 10;
	localparam int MAGIC_TOTAL_LIMIT = 1000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_ROWS     = 2'd0,
		CFG_MAGIC_ENABLE   = 2'd1,
		CFG_COMB_THRESHOLD = 2'd2
	} cfg_reg_t;

	typedef enum logic [1:0] {
		FRAME_PREV = 2'd0,
		FRAME_CURR = 2'd1,
		FRAME_NEXT = 2'd2
	} frame_sel_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic [PIX_W-1:0] cur_pixel;
		logic [PIX_W-1:0] prev_above;
		logic [PIX_W-1:0] prev_below;
		logic [PIX_W-1:0] curr_above;
		logic [PIX_W-1:0] curr_below;
		logic [PIX_W-1:0] next_above;
		logic [PIX_W-1:0] next_below;
		logic             last_sample;
	} in_beat_t;

	typedef struct packed {
		logic [1:0]           chosen_frame;
		logic [OUT_CNT_W-1:0] prev_comb_count;
		logic [OUT_CNT_W-1:0] curr_comb_count;
		logic [OUT_CNT_W-1:0] next_comb_count;
	} out_beat_t;

	// comb hits of one position, handed from detect to decide
	typedef struct packed {
		logic valid;
		logic last;
		logic prev_hit;
		logic curr_hit;
		logic next_hit;
	} hit_flags_t;

endpackage

[design/fmcs_detect.sv]
// Sample gating and comb product tests, registered into stage 2.
module fmcs_detect (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           valid_s1,
	input  fmcs_pkg::in_beat_t             beat_s1,
	input  logic [fmcs_pkg::ROWS_W-1:0]    frame_rows,
	input  logic [fmcs_pkg::THR_W-1:0]     comb_threshold,
	input  logic                           hold,
	output fmcs_pkg::hit_flags_t           flags_s2
);

	logic                     sampled;
	logic                     prev_c, curr_c, next_c;
	logic signed [17:0]       thr;

	function automatic logic combed(input logic [fmcs_pkg::PIX_W-1:0] cur,
	                                input logic [fmcs_pkg::PIX_W-1:0] above,
	                                input logic [fmcs_pkg::PIX_W-1:0] below,
	                                input logic signed [17:0] limit);
		logic signed [8:0]  da;
		logic signed [8:0]  db;
		logic signed [17:0] prod;
		da   = $signed({1'b0, above}) - $signed({1'b0, cur});
		db   = $signed({1'b0, below}) - $signed({1'b0, cur});
		prod = da * db;
		return prod > limit;
	endfunction

	assign thr = $signed({2'b00, comb_threshold});

	assign sampled = (beat_s1.col[3:2] == 2'b00) && (beat_s1.row[1:0] == 2'b00) &&
		(({2'b00, beat_s1.row} + 14'd2) < {1'b0, frame_rows});

	assign prev_c = combed(beat_s1.cur_pixel, beat_s1.prev_above, beat_s1.prev_below, thr);
	assign curr_c = combed(beat_s1.cur_pixel, beat_s1.curr_above, beat_s1.curr_below, thr);
	assign next_c = combed(beat_s1.cur_pixel, beat_s1.next_above, beat_s1.next_below, thr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s2 <= '0;
		end else if (!hold) begin
			flags_s2.valid    <= valid_s1;
			flags_s2.last     <= beat_s1.last_sample;
			flags_s2.prev_hit <= sampled & prev_c;
			flags_s2.curr_hit <= sampled & curr_c;
			flags_s2.next_hit <= sampled & next_c;
		end
	end

endmodule

[design/fmcs_decide.sv]
// Saturating comb counters, frame decision and result register.
module fmcs_decide #(
	parameter int COUNT_BITS = 18
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fmcs_pkg::hit_flags_t  flags_s2,
	input  logic                  magic_enable,
	output logic                  hold,
	output logic                  out_valid,
	input  logic                  out_ready,
	output fmcs_pkg::out_beat_t   out_data
);

	localparam int SUM_W = COUNT_BITS + 2;
	localparam int EXT_W = COUNT_BITS + fmcs_pkg::OUT_CNT_W;

	logic [COUNT_BITS-1:0] prev_q, curr_q, next_q;
	logic [COUNT_BITS-1:0] prev_n, curr_n, next_n;
	logic [COUNT_BITS-1:0] lowest, diff;
	logic [SUM_W-1:0]      total;
	logic [EXT_W-1:0]      prev_ext, curr_ext, next_ext;
	fmcs_pkg::frame_sel_t  pick, chosen;
	logic                  fire, magic_hit;

	assign hold = flags_s2.valid & flags_s2.last & out_valid & ~out_ready;
	assign fire = flags_s2.valid & ~hold;

	assign prev_n = prev_q + COUNT_BITS'(flags_s2.prev_hit & ~(&prev_q));
	assign curr_n = curr_q + COUNT_BITS'(flags_s2.curr_hit & ~(&curr_q));
	assign next_n = next_q + COUNT_BITS'(flags_s2.next_hit & ~(&next_q));

	always_comb begin
		lowest = curr_n;
		pick   = fmcs_pkg::FRAME_CURR;
		if (prev_n < lowest) begin
			lowest = prev_n;
			pick   = fmcs_pkg::FRAME_PREV;
		end
		if (next_n < lowest) begin
			lowest = next_n;
			pick   = fmcs_pkg::FRAME_NEXT;
		end
	end

	// lowest never exceeds current
	assign diff  = curr_n - lowest;
	assign total = SUM_W'(prev_n) + SUM_W'(curr_n) + SUM_W'(next_n);

	assign magic_hit = magic_enable &&
		(curr_n < COUNT_BITS'(fmcs_pkg::MAGIC_CURR_LIMIT)) &&
		(diff < COUNT_BITS'(fmcs_pkg::MAGIC_DIFF_LIMIT)) &&
		(total > SUM_W'(fmcs_pkg::MAGIC_TOTAL_LIMIT));

	assign chosen = magic_hit ? fmcs_pkg::FRAME_CURR : pick;

	assign prev_ext = {{fmcs_pkg::OUT_CNT_W{1'b0}}, prev_n};
	assign curr_ext = {{fmcs_pkg::OUT_CNT_W{1'b0}}, curr_n};
	assign next_ext = {{fmcs_pkg::OUT_CNT_W{1'b0}}, next_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			curr_q <= '0;
			next_q <= '0;
		end else if (fire) begin
			if (flags_s2.last) begin
				prev_q <= '0;
				curr_q <= '0;
				next_q <= '0;
			end else begin
				prev_q <= prev_n;
				curr_q <= curr_n;
				next_q <= next_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire && flags_s2.last) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && flags_s2.last) begin
			out_data.chosen_frame    <= chosen;
			out_data.prev_comb_count <= prev_ext[fmcs_pkg::OUT_CNT_W-1:0];
			out_data.curr_comb_count <= curr_ext[fmcs_pkg::OUT_CNT_W-1:0];
			out_data.next_comb_count <= next_ext[fmcs_pkg::OUT_CNT_W-1:0];
		end
	end

	a_clear_after_decision: assert property (@(posedge clk) disable iff (!arst_n)
		fire && flags_s2.last |=> (prev_q <= COUNT_BITS'(1)) && (curr_q <= COUNT_BITS'(1)) &&
			(next_q <= COUNT_BITS'(1)))
		else $error("counters not cleared after decision");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("pending result overwritten");

	a_choice_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.chosen_frame == fmcs_pkg::FRAME_PREV) ||
			(out_data.chosen_frame == fmcs_pkg::FRAME_CURR) ||
			(out_data.chosen_frame == fmcs_pkg::FRAME_NEXT))
		else $error("invalid frame choice");

	a_prev_strictly_lower: assert property (@(posedge clk) disable iff (!arst_n)
		fire && flags_s2.last && chosen == fmcs_pkg::FRAME_PREV |->
			(prev_n < curr_n) && (prev_n <= next_n))
		else $error("previous chosen without fewest combed positions");

endmodule

[design/field_match_comb_selector_top.sv]
// Top level of the field match comb selector: input stage, config registers, handshakes.
//
// Usage: one luma position per beat on in_valid/in_ready with payload in_data. The
// block counts combed sampled positions against the previous, current and next frames.
// The beat with last_sample set closes the frame: one result beat then leaves on
// out_valid/out_ready carrying the chosen frame and the three counts, and the counters
// restart from zero. Beats without last_sample produce nothing on the output.
// Throughput: one input beat per cycle while no final beat is held, set by the single
// input register and the registered comb test feeding the counters directly.
// Result path: once the last beat is accepted, its comb flags are registered, then the
// result register loads and out_valid rises, unless that beat is held.
// Stall: while a result waits on out_ready, non-final beats keep flowing; only a
// further final beat holds in stage 2 until the pending result is taken.
// Config: cfg_valid/cfg_ready with cfg_index and cfg_data, always ready; write only
// while idle. Index 0 frame_rows, 1 magic_enable, 2 comb_threshold; others ignored.
// Reset: arst_n clears the pipeline, counters and output valid, and sets frame_rows
// to 480, magic_enable to 0 and comb_threshold to 100.
module field_match_comb_selector_top #(
	parameter int COUNT_BITS = 18
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  fmcs_pkg::in_beat_t                in_data,
	output logic                              out_valid,
	input  logic                              out_ready,
	output fmcs_pkg::out_beat_t               out_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [fmcs_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [fmcs_pkg::CFG_DATA_W-1:0]   cfg_data
);

	logic                          valid_s1;
	fmcs_pkg::in_beat_t            beat_s1;
	logic [fmcs_pkg::ROWS_W-1:0]   frame_rows_q;
	logic                          magic_enable_q;
	logic [fmcs_pkg::THR_W-1:0]    comb_threshold_q;
	fmcs_pkg::hit_flags_t          flags_s2;
	logic                          hold;

	assign cfg_ready = 1'b1;
	assign in_ready  = ~valid_s1 | ~hold;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_rows_q     <= fmcs_pkg::ROWS_W'(480);
			magic_enable_q   <= 1'b0;
			comb_threshold_q <= fmcs_pkg::THR_W'(100);
		end else if (cfg_valid) begin
			unique case (fmcs_pkg::cfg_reg_t'(cfg_index))
				fmcs_pkg::CFG_FRAME_ROWS:     frame_rows_q     <= cfg_data[fmcs_pkg::ROWS_W-1:0];
				fmcs_pkg::CFG_MAGIC_ENABLE:   magic_enable_q   <= cfg_data[0];
				fmcs_pkg::CFG_COMB_THRESHOLD: comb_threshold_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= in_data;
		end
	end

	fmcs_detect u_detect (
		.clk            (clk),
		.arst_n         (arst_n),
		.valid_s1       (valid_s1),
		.beat_s1        (beat_s1),
		.frame_rows     (frame_rows_q),
		.comb_threshold (comb_threshold_q),
		.hold           (hold),
		.flags_s2       (flags_s2)
	);

	fmcs_decide #(
		.COUNT_BITS (COUNT_BITS)
	) u_decide (
		.clk          (clk),
		.arst_n       (arst_n),
		.flags_s2     (flags_s2),
		.magic_enable (magic_enable_q),
		.hold         (hold),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data)
	);

endmodule

[test/field_match_comb_selector_top_test.sv]
// Testbench for field_match_comb_selector_top: directed and random frames checked against a predictor.
`timescale 1ns / 1ps

module field_match_comb_selector_top_test;

	localparam int COUNT_BITS = 18;
	localparam int unsigned COUNT_MAX = (1 << COUNT_BITS) - 1;
	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int SETTLE_CYCLES = 8;
	localparam logic [fmcs_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	fmcs_pkg::in_beat_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	fmcs_pkg::out_beat_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [fmcs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [fmcs_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	field_match_comb_selector_top #(.COUNT_BITS(COUNT_BITS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// predictor state
	logic [fmcs_pkg::ROWS_W-1:0] rows_cfg = 13'd480;
	logic magic_on = 1'b0;
	logic [fmcs_pkg::THR_W-1:0] thr_cfg = 16'd100;
	int unsigned prev_combs = 0;
	int unsigned curr_combs = 0;
	int unsigned next_combs = 0;
	fmcs_pkg::out_beat_t frame_results_due[$];

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int hold_len = 0;
	int hold_go = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mismatches = 0;
	int cycle_count = 0;

	function automatic bit is_combed(logic [fmcs_pkg::PIX_W-1:0] centre,
			logic [fmcs_pkg::PIX_W-1:0] above, logic [fmcs_pkg::PIX_W-1:0] below);
		int c, da, db, thr;
		c = centre;
		da = above;
		db = below;
		thr = thr_cfg;
		da = da - c;
		db = db - c;
		return (da * db) > thr;
	endfunction

	function automatic fmcs_pkg::out_beat_t decide_frame();
		int unsigned lowest;
		fmcs_pkg::frame_sel_t pick;
		fmcs_pkg::out_beat_t res;
		lowest = curr_combs;
		pick = fmcs_pkg::FRAME_CURR;
		if (prev_combs < lowest) begin
			lowest = prev_combs;
			pick = fmcs_pkg::FRAME_PREV;
		end
		if (next_combs < lowest) begin
			lowest = next_combs;
			pick = fmcs_pkg::FRAME_NEXT;
		end
		if (magic_on && curr_combs < fmcs_pkg::MAGIC_CURR_LIMIT
				&& curr_combs - lowest < fmcs_pkg::MAGIC_DIFF_LIMIT
				&& prev_combs + curr_combs + next_combs > fmcs_pkg::MAGIC_TOTAL_LIMIT)
			pick = fmcs_pkg::FRAME_CURR;
		res.chosen_frame = pick;
		res.prev_comb_count = prev_combs[fmcs_pkg::OUT_CNT_W-1:0];
		res.curr_comb_count = curr_combs[fmcs_pkg::OUT_CNT_W-1:0];
		res.next_comb_count = next_combs[fmcs_pkg::OUT_CNT_W-1:0];
		return res;
	endfunction

	task automatic tally_beat(input fmcs_pkg::in_beat_t b);
		int row_i, lim;
		row_i = b.row;
		lim = rows_cfg;
		lim = lim - 2;
		if (b.col[3:0] < 4 && b.row[1:0] == 2'd0 && row_i < lim) begin
			if (is_combed(b.cur_pixel, b.prev_above, b.prev_below) && prev_combs < COUNT_MAX)
				prev_combs++;
			if (is_combed(b.cur_pixel, b.curr_above, b.curr_below) && curr_combs < COUNT_MAX)
				curr_combs++;
			if (is_combed(b.cur_pixel, b.next_above, b.next_below) && next_combs < COUNT_MAX)
				next_combs++;
		end
		if (b.last_sample) begin
			frame_results_due.push_back(decide_frame());
			prev_combs = 0;
			curr_combs = 0;
			next_combs = 0;
		end
	endtask

	function automatic fmcs_pkg::in_beat_t make_beat(int col, int row, int centre, int pa,
			int pb, int ca, int cb, int na, int nb, bit last);
		fmcs_pkg::in_beat_t b;
		b.col = fmcs_pkg::COL_W'(col);
		b.row = fmcs_pkg::ROW_W'(row);
		b.cur_pixel = fmcs_pkg::PIX_W'(centre);
		b.prev_above = fmcs_pkg::PIX_W'(pa);
		b.prev_below = fmcs_pkg::PIX_W'(pb);
		b.curr_above = fmcs_pkg::PIX_W'(ca);
		b.curr_below = fmcs_pkg::PIX_W'(cb);
		b.next_above = fmcs_pkg::PIX_W'(na);
		b.next_below = fmcs_pkg::PIX_W'(nb);
		b.last_sample = last;
		return b;
	endfunction

	// full-scale neighbours on a hit, flat pixels otherwise
	function automatic fmcs_pkg::in_beat_t hit_beat(bit hp, bit hc, bit hn, bit last);
		return make_beat(0, 0, 0, hp ? 255 : 0, hp ? 255 : 0, hc ? 255 : 0, hc ? 255 : 0,
			hn ? 255 : 0, hn ? 255 : 0, last);
	endfunction

	function automatic fmcs_pkg::in_beat_t random_beat(bit last);
		fmcs_pkg::in_beat_t b;
		b.col = fmcs_pkg::COL_W'($urandom_range(0, 4095));
		b.row = fmcs_pkg::ROW_W'($urandom_range(0, 4095));
		if ($urandom_range(0, 3) != 0)
			b.col[3:2] = 2'b00;
		if ($urandom_range(0, 3) != 0)
			b.row[1:0] = 2'b00;
		b.cur_pixel = fmcs_pkg::PIX_W'($urandom_range(0, 255));
		b.prev_above = fmcs_pkg::PIX_W'($urandom_range(0, 255));
		b.prev_below = fmcs_pkg::PIX_W'($urandom_range(0, 255));
		b.curr_above = fmcs_pkg::PIX_W'($urandom_range(0, 255));
		b.curr_below = fmcs_pkg::PIX_W'($urandom_range(0, 255));
		b.next_above = fmcs_pkg::PIX_W'($urandom_range(0, 255));
		b.next_below = fmcs_pkg::PIX_W'($urandom_range(0, 255));
		b.last_sample = last;
		return b;
	endfunction

	task automatic send_beat(input fmcs_pkg::in_beat_t b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (!in_ready);
		tally_beat(b);
	endtask

	task automatic send_frame(input int n_prev, input int n_curr, input int n_next);
		int total;
		total = (n_prev > n_curr) ? n_prev : n_curr;
		total = (n_next > total) ? n_next : total;
		total = (total < 1) ? 1 : total;
		for (int i = 0; i < total; i++)
			send_beat(hit_beat(i < n_prev, i < n_curr, i < n_next, i == total - 1));
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (frame_results_due.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [fmcs_pkg::CFG_IDX_W-1:0] idx,
			input logic [fmcs_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (fmcs_pkg::cfg_reg_t'(idx))
			fmcs_pkg::CFG_FRAME_ROWS: rows_cfg = data[fmcs_pkg::ROWS_W-1:0];
			fmcs_pkg::CFG_MAGIC_ENABLE: magic_on = data[0];
			fmcs_pkg::CFG_COMB_THRESHOLD: thr_cfg = data[fmcs_pkg::THR_W-1:0];
			default: ;
		endcase
	endtask

	task automatic report_mismatch(input string what, input fmcs_pkg::out_beat_t want,
			input fmcs_pkg::out_beat_t got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t %s: expected frame %0d counts %0d/%0d/%0d, got %0d counts %0d/%0d/%0d",
				$time, what, want.chosen_frame, want.prev_comb_count, want.curr_comb_count,
				want.next_comb_count, got.chosen_frame, got.prev_comb_count, got.curr_comb_count,
				got.next_comb_count);
	endtask

	always @(posedge clk) begin
		fmcs_pkg::out_beat_t want;
		if (out_valid && out_ready) begin
			if (frame_results_due.size() == 0) begin
				report_mismatch("unexpected result beat", '0, out_data);
			end else begin
				want = frame_results_due.pop_front();
				if (out_data.chosen_frame !== want.chosen_frame
						|| out_data.prev_comb_count !== want.prev_comb_count
						|| out_data.curr_comb_count !== want.curr_comb_count
						|| out_data.next_comb_count !== want.next_comb_count)
					report_mismatch("result beat differs", want, out_data);
			end
		end
	end

	always @(posedge clk) begin
		if (hold_go != hold_seen) begin
			hold_seen = hold_go;
			hold_left = hold_len;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("field_match_comb_selector_top_test: done, errors");
			$finish;
		end
	end

	// reset values: 480 rows, threshold 100, override off
	task automatic test_default_config();
		send_beat(make_beat(0, 0, 0, 10, 10, 10, 11, 9, 255, 0));
		send_beat(make_beat(3, 0, 128, 255, 0, 0, 255, 128, 128, 0));
		send_beat(make_beat(4, 0, 0, 255, 255, 255, 255, 255, 255, 0));
		send_beat(make_beat(4083, 4, 255, 0, 0, 0, 0, 0, 0, 0));
		send_beat(make_beat(16, 1, 0, 255, 255, 255, 255, 255, 255, 0));
		send_beat(make_beat(17, 2, 0, 255, 255, 255, 255, 255, 255, 0));
		send_beat(make_beat(18, 3, 0, 255, 255, 255, 255, 255, 255, 0));
		send_beat(make_beat(4095, 4095, 255, 255, 255, 255, 255, 255, 255, 0));
		send_beat(make_beat(2, 476, 0, 200, 200, 0, 0, 255, 255, 0));
		send_beat(make_beat(1, 480, 0, 255, 255, 255, 255, 255, 255, 0));
		send_beat(make_beat(0, 0, 255, 0, 0, 0, 0, 0, 0, 1));
		send_beat(make_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
	endtask

	task automatic test_sampling_window();
		logic [fmcs_pkg::CFG_DATA_W-1:0] rows_list[8] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd6,
			16'd7, 16'd4096, 16'hFFFF};
		foreach (rows_list[i]) begin
			wait_drained();
			cfg_write(fmcs_pkg::CFG_FRAME_ROWS, rows_list[i]);
			send_beat(make_beat(0, 0, 0, 255, 255, 255, 255, 255, 255, 0));
			send_beat(make_beat(1, 4, 0, 255, 255, 255, 255, 255, 255, 0));
			send_beat(make_beat(2, 4092, 0, 255, 255, 255, 255, 0, 0, 1));
		end
		wait_drained();
		cfg_write(CFG_UNUSED, 16'h0005);
		cfg_write(fmcs_pkg::CFG_FRAME_ROWS, 16'd480);
		send_beat(make_beat(0, 0, 0, 255, 255, 0, 0, 0, 0, 1));
	endtask

	task automatic test_comb_threshold();
		logic [fmcs_pkg::CFG_DATA_W-1:0] thr_list[5] = '{16'd0, 16'd1, 16'd65024, 16'd65025,
			16'd65535};
		foreach (thr_list[i]) begin
			wait_drained();
			cfg_write(fmcs_pkg::CFG_COMB_THRESHOLD, thr_list[i]);
			send_beat(make_beat(0, 0, 0, 1, 1, 0, 0, 255, 255, 0));
			send_beat(make_beat(1, 0, 255, 0, 0, 254, 254, 0, 255, 0));
			send_beat(make_beat(2, 0, 2, 0, 4, 1, 3, 2, 2, 1));
		end
		wait_drained();
		cfg_write(fmcs_pkg::CFG_COMB_THRESHOLD, 16'd100);
	endtask

	task automatic test_tie_break();
		send_frame(0, 0, 0);
		send_frame(2, 2, 2);
		send_frame(1, 2, 1);
		send_frame(3, 2, 1);
		send_frame(1, 1, 2);
		send_frame(2, 3, 2);
		send_frame(3, 2, 2);
		send_frame(4, 5, 3);
	endtask

	task automatic test_magic_override();
		wait_drained();
		cfg_write(fmcs_pkg::CFG_MAGIC_ENABLE, 16'h0001);
		send_frame(3, 8, 1);
		send_frame(6, 9, 4);
		wait_drained();
		cfg_write(fmcs_pkg::CFG_MAGIC_ENABLE, 16'hFFFE);
		send_frame(3, 8, 1);
	endtask

	task automatic test_back_pressure();
		wait_drained();
		hold_len = 150;
		hold_go++;
		for (int i = 0; i < 40; i++)
			send_beat(random_beat(i % 4 == 3));
		wait_drained();
		hold_len = 60;
		hold_go++;
		for (int i = 0; i < 20; i++)
			send_beat(random_beat(i % 5 == 4));
		wait_drained();
		for (int i = 0; i < 20; i++)
			send_beat(random_beat(i % 3 == 2));
	endtask

	task automatic random_config();
		logic [fmcs_pkg::CFG_DATA_W-1:0] rows_val, thr_val;
		case ($urandom_range(0, 9))
			0: rows_val = fmcs_pkg::CFG_DATA_W'($urandom_range(0, 2));
			1: rows_val = 16'hFFFF;
			default: rows_val = fmcs_pkg::CFG_DATA_W'($urandom_range(3, 4096));
		endcase
		if ($urandom_range(0, 3) == 0)
			thr_val = fmcs_pkg::CFG_DATA_W'($urandom_range(0, 65535));
		else
			thr_val = fmcs_pkg::CFG_DATA_W'($urandom_range(0, 3000));
		cfg_write(fmcs_pkg::CFG_FRAME_ROWS, rows_val);
		cfg_write(fmcs_pkg::CFG_MAGIC_ENABLE, fmcs_pkg::CFG_DATA_W'($urandom_range(0, 65535)));
		cfg_write(fmcs_pkg::CFG_COMB_THRESHOLD, thr_val);
	endtask

	task automatic test_random_frames();
		int sent;
		int frame_len;
		for (int phase = 0; phase < 3; phase++) begin
			wait_drained();
			case (phase)
				0: begin
					send_idle_pct = 36;
					recv_idle_pct = 79;
				end
				1: begin
					send_idle_pct = 79;
					recv_idle_pct = 36;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			random_config();
			sent = 0;
			while (sent < 90) begin
				frame_len = $urandom_range(1, 12);
				for (int i = 0; i < frame_len; i++)
					send_beat(random_beat(i == frame_len - 1));
				sent += frame_len;
				if (sent >= 45 && sent - frame_len < 45)
					wait_drained();
			end
		end
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_default_config();
		test_sampling_window();
		test_comb_threshold();
		test_tie_break();
		test_magic_override();
		test_back_pressure();
		test_random_frames();
		wait_drained();
		if (mismatches == 0)
			$display("field_match_comb_selector_top_test: done, clean");
		else
			$display("field_match_comb_selector_top_test: done, errors");
		$finish;
	end

endmodule

[sim.f]
design/fmcs_pkg.sv
design/fmcs_detect.sv
design/fmcs_decide.sv
design/field_match_comb_selector_top.sv
test/field_match_comb_selector_top_test.sv
